>>> src/skin_pixel_centroid_defines.svh
// ----------------------------------------------------------------------------
// Skin pixel centroid assertion macros
// Shared concurrent assertion forms used by the controller.
// ----------------------------------------------------------------------------
`ifndef SKIN_PIXEL_CENTROID_DEFINES_SVH
`define SKIN_PIXEL_CENTROID_DEFINES_SVH

`ifndef ASSERT_OFF

// Condition in the same cycle.
`define SPC_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("spc assertion failed");

// Condition in the following cycle.
`define SPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("spc assertion failed");

`else

`define SPC_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define SPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> src/spc_pkg.sv
// ----------------------------------------------------------------------------
// Skin pixel centroid package
// Widths, register indexes and the command and status bundles shared by the
// controller and the datapath.
// ----------------------------------------------------------------------------
package spc_pkg;

    // Coordinate counters and frame size.
    localparam int COORD_BITS  = 12;
    localparam int DIM_BITS    = 13;
    localparam int CENTER_BITS = 12;
    localparam int SUM_BITS    = 37;
    localparam int CNT_BITS    = 25;
    localparam int PIX_BITS    = 8;
    localparam int CFG_BITS    = 25;
    localparam int IDX_BITS    = 3;
    localparam int STEP_BITS   = 6;
    localparam int DIV_STEPS   = SUM_BITS;

    localparam logic [DIM_BITS-1:0] MAX_DIM = DIM_BITS'(1 << COORD_BITS);

    // Configuration register indexes.
    typedef enum logic [IDX_BITS-1:0] {
        REG_FRAME_WIDTH     = 3'd0,
        REG_FRAME_HEIGHT    = 3'd1,
        REG_VALUE_MIN       = 3'd2,
        REG_SAT_LOW_TENTHS  = 3'd3,
        REG_SAT_HIGH_TENTHS = 3'd4,
        REG_HUE_MAX_DEG     = 3'd5,
        REG_MIN_SKIN_PIXELS = 3'd6
    } t_reg_index;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic update;
        logic div_step;
        logic div_load_y;
        logic div_store_y;
        logic emit;
    } t_spc_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic frame_done;
        logic use_div;
        logic step_last;
    } t_spc_status;

    // Frame size as used: zero acts as one, oversize clamps to the maximum.
    function automatic logic [DIM_BITS-1:0] eff_dim(input logic [DIM_BITS-1:0] v);
        logic [DIM_BITS-1:0] res;
        if (v == '0) begin
            res = DIM_BITS'(1);
        end else if (v > MAX_DIM) begin
            res = MAX_DIM;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

>>> src/spc_datapath.sv
// ----------------------------------------------------------------------------
// Skin pixel centroid datapath
// Configuration registers, skin classifier, position counters, running sums,
// a shared restoring divider and the output register.
// ----------------------------------------------------------------------------
module spc_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [spc_pkg::IDX_BITS-1:0]  i_cfg_index,
    input  logic [spc_pkg::CFG_BITS-1:0]  i_cfg_data,
    input  logic [spc_pkg::PIX_BITS-1:0]  i_red,
    input  logic [spc_pkg::PIX_BITS-1:0]  i_green,
    input  logic [spc_pkg::PIX_BITS-1:0]  i_blue,
    input  spc_pkg::t_spc_cmd             i_cmd,
    output spc_pkg::t_spc_status          o_status,
    output logic                          o_skin_flag,
    output logic                          o_frame_done,
    output logic [spc_pkg::CENTER_BITS-1:0] o_center_x,
    output logic [spc_pkg::CENTER_BITS-1:0] o_center_y,
    output logic [spc_pkg::CNT_BITS-1:0]  o_skin_count
);
    import spc_pkg::*;

    // Configuration registers.
    logic [DIM_BITS-1:0]  r_frame_width;
    logic [DIM_BITS-1:0]  r_frame_height;
    logic [7:0]           r_value_min;
    logic [3:0]           r_sat_low;
    logic [3:0]           r_sat_high;
    logic [5:0]           r_hue_max;
    logic [CNT_BITS-1:0]  r_min_skin;

    // Frame state.
    logic [COORD_BITS-1:0] r_col;
    logic [COORD_BITS-1:0] r_row;
    logic [SUM_BITS-1:0]   r_sum_x;
    logic [SUM_BITS-1:0]   r_sum_y;
    logic [CNT_BITS-1:0]   r_total;

    // Captured pixel.
    logic [PIX_BITS-1:0] r_red;
    logic [PIX_BITS-1:0] r_green;
    logic [PIX_BITS-1:0] r_blue;

    // Result and divider registers.
    logic                   r_skin;
    logic                   r_done;
    logic [CENTER_BITS-1:0] r_cx;
    logic [CENTER_BITS-1:0] r_cy;
    logic [CNT_BITS-1:0]    r_cnt;
    logic [SUM_BITS-1:0]    r_divd;
    logic [SUM_BITS-1:0]    r_snap_y;
    logic [CNT_BITS-1:0]    r_divisor;
    logic [CNT_BITS-1:0]    r_rem;
    logic [STEP_BITS-1:0]   r_step;

    // Output register.
    logic                   r_o_skin;
    logic                   r_o_done;
    logic [CENTER_BITS-1:0] r_o_cx;
    logic [CENTER_BITS-1:0] r_o_cy;
    logic [CNT_BITS-1:0]    r_o_cnt;

    logic [DIM_BITS-1:0]   w_eff;
    logic [DIM_BITS-1:0]   h_eff;
    logic [COORD_BITS-1:0] w_last;
    logic [COORD_BITS-1:0] h_last;
    logic                  last_col;
    logic                  last_row;
    logic                  done;
    logic                  order_ok;
    logic [7:0]            d_rb;
    logic [7:0]            d_gb;
    logic [13:0]           hue_lhs;
    logic [13:0]           hue_rhs;
    logic [11:0]           ten_d;
    logic [11:0]           low_rhs;
    logic [11:0]           high_rhs;
    logic                  skin;
    logic [SUM_BITS-1:0]   n_sum_x;
    logic [SUM_BITS-1:0]   n_sum_y;
    logic [CNT_BITS-1:0]   n_total;
    logic                  use_div;
    logic [CNT_BITS:0]     trial;
    logic [CNT_BITS:0]     diff;
    logic                  q_bit;
    logic [SUM_BITS-1:0]   n_divd;
    logic [CNT_BITS-1:0]   n_rem;

    // Position of the captured pixel within the frame.
    always_comb begin
        w_eff    = eff_dim(r_frame_width);
        h_eff    = eff_dim(r_frame_height);
        w_last   = COORD_BITS'(w_eff - DIM_BITS'(1));
        h_last   = COORD_BITS'(h_eff - DIM_BITS'(1));
        last_col = (r_col >= w_last);
        last_row = (r_row >= h_last);
        done     = last_col && last_row;
    end

    // Skin test in exact integer form of the hue, saturation and value rules.
    always_comb begin
        order_ok = (r_red >= r_green) && (r_green > r_blue);
        d_rb     = r_red - r_blue;
        d_gb     = r_green - r_blue;
        hue_lhs  = 14'(d_gb) * 14'd60;
        hue_rhs  = 14'(r_hue_max) * 14'(d_rb);
        ten_d    = 12'(d_rb) * 12'd10;
        low_rhs  = 12'(r_sat_low) * 12'(r_red);
        high_rhs = 12'(r_sat_high) * 12'(r_red);
        skin     = order_ok && (hue_lhs < hue_rhs) && (ten_d > low_rhs)
                   && (ten_d < high_rhs) && (r_red > r_value_min);
    end

    // Running sums including the captured pixel.
    always_comb begin
        n_sum_x = r_sum_x + (skin ? SUM_BITS'(r_col) : '0);
        n_sum_y = r_sum_y + (skin ? SUM_BITS'(r_row) : '0);
        n_total = r_total + CNT_BITS'(skin);
        use_div = (n_total != '0) && (n_total >= r_min_skin);
    end

    // One restoring division step.
    always_comb begin
        trial  = {r_rem, r_divd[SUM_BITS-1]};
        diff   = trial - {1'b0, r_divisor};
        q_bit  = (trial >= {1'b0, r_divisor});
        n_rem  = q_bit ? diff[CNT_BITS-1:0] : trial[CNT_BITS-1:0];
        n_divd = {r_divd[SUM_BITS-2:0], q_bit};
    end

    assign o_status.frame_done = done;
    assign o_status.use_div    = use_div;
    assign o_status.step_last  = (r_step == STEP_BITS'(DIV_STEPS - 1));

    // Configuration writes, position counters and sums.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= DIM_BITS'(640);
            r_frame_height <= DIM_BITS'(480);
            r_value_min    <= 8'd51;
            r_sat_low      <= 4'd2;
            r_sat_high     <= 4'd8;
            r_hue_max      <= 6'd40;
            r_min_skin     <= CNT_BITS'(100);
            r_col          <= '0;
            r_row          <= '0;
            r_sum_x        <= '0;
            r_sum_y        <= '0;
            r_total        <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_FRAME_WIDTH:     r_frame_width  <= i_cfg_data[DIM_BITS-1:0];
                    REG_FRAME_HEIGHT:    r_frame_height <= i_cfg_data[DIM_BITS-1:0];
                    REG_VALUE_MIN:       r_value_min    <= i_cfg_data[7:0];
                    REG_SAT_LOW_TENTHS:  r_sat_low      <= i_cfg_data[3:0];
                    REG_SAT_HIGH_TENTHS: r_sat_high     <= i_cfg_data[3:0];
                    REG_HUE_MAX_DEG:     r_hue_max      <= i_cfg_data[5:0];
                    REG_MIN_SKIN_PIXELS: r_min_skin     <= i_cfg_data[CNT_BITS-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.update) begin
                if (done) begin
                    r_col   <= '0;
                    r_row   <= '0;
                    r_sum_x <= '0;
                    r_sum_y <= '0;
                    r_total <= '0;
                end else begin
                    r_sum_x <= n_sum_x;
                    r_sum_y <= n_sum_y;
                    r_total <= n_total;
                    if (last_col) begin
                        r_col <= '0;
                        r_row <= r_row + COORD_BITS'(1);
                    end else begin
                        r_col <= r_col + COORD_BITS'(1);
                    end
                end
            end
        end
    end

    // Pixel capture, per-item results and the divider.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
        end
        if (i_cmd.update) begin
            r_skin <= skin;
            r_done <= done;
            if (done) begin
                r_cnt <= n_total;
                if (use_div) begin
                    r_divd    <= n_sum_x;
                    r_snap_y  <= n_sum_y;
                    r_divisor <= n_total;
                    r_rem     <= '0;
                    r_step    <= '0;
                end else begin
                    r_cx <= CENTER_BITS'(w_eff >> 1);
                    r_cy <= CENTER_BITS'(h_eff >> 1);
                end
            end else begin
                r_cnt <= '0;
                r_cx  <= '0;
                r_cy  <= '0;
            end
        end else if (i_cmd.div_load_y) begin
            // The column quotient is complete with this step; start on rows.
            r_cx   <= n_divd[CENTER_BITS-1:0];
            r_divd <= r_snap_y;
            r_rem  <= '0;
            r_step <= '0;
        end else if (i_cmd.div_step) begin
            r_divd <= n_divd;
            r_rem  <= n_rem;
            r_step <= r_step + STEP_BITS'(1);
            if (i_cmd.div_store_y) begin
                r_cy <= n_divd[CENTER_BITS-1:0];
            end
        end
        if (i_cmd.emit) begin
            r_o_skin <= r_skin;
            r_o_done <= r_done;
            r_o_cx   <= r_cx;
            r_o_cy   <= r_cy;
            r_o_cnt  <= r_cnt;
        end
    end

    assign o_skin_flag  = r_o_skin;
    assign o_frame_done = r_o_done;
    assign o_center_x   = r_o_cx;
    assign o_center_y   = r_o_cy;
    assign o_skin_count = r_o_cnt;

endmodule

>>> src/spc_ctrl.sv
// ----------------------------------------------------------------------------
// Skin pixel centroid controller
// Sequences capture, classification, the two centroid divisions and the
// hand-off of each result to the output register.
// ----------------------------------------------------------------------------
`include "skin_pixel_centroid_defines.svh"

module spc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  spc_pkg::t_spc_status i_status,
    output spc_pkg::t_spc_cmd    o_cmd
);
    import spc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_DIVX,
        S_DIVY,
        S_EMIT
    } t_state;

    t_state   r_state;
    logic     r_in_ready;
    logic     r_out_valid;
    logic     out_free;
    t_spc_cmd cmd;

    assign out_free = !r_out_valid || i_out_ready;

    // Commands decoded from the current state.
    always_comb begin
        cmd = '0;
        unique case (r_state)
            S_IDLE: cmd.capture = i_in_valid && r_in_ready;
            S_CALC: cmd.update  = 1'b1;
            S_DIVX: begin
                cmd.div_step   = 1'b1;
                cmd.div_load_y = i_status.step_last;
            end
            S_DIVY: begin
                cmd.div_step    = 1'b1;
                cmd.div_store_y = i_status.step_last;
            end
            S_EMIT: cmd.emit = out_free;
            default: begin
            end
        endcase
    end

    // State, input ready and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (cmd.capture) begin
                        r_state    <= S_CALC;
                        r_in_ready <= 1'b0;
                    end
                end
                S_CALC: begin
                    if (i_status.frame_done && i_status.use_div) begin
                        r_state <= S_DIVX;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_DIVX: begin
                    if (i_status.step_last) begin
                        r_state <= S_DIVY;
                    end
                end
                S_DIVY: begin
                    if (i_status.step_last) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_state    <= S_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    // Ready is only offered while waiting for a pixel.
    `SPC_ASSERT_SAME(a_ready_idle, i_clk, i_rst_n, r_in_ready, r_state == S_IDLE)
    // A result never overwrites one that has not been taken.
    `SPC_ASSERT_SAME(a_emit_free, i_clk, i_rst_n, cmd.emit, !r_out_valid || i_out_ready)
    // A captured pixel is classified in the next cycle.
    `SPC_ASSERT_NEXT(a_capture_calc, i_clk, i_rst_n, cmd.capture, r_state == S_CALC)
    // The divider only runs for a frame end with enough skin pixels.
    `SPC_ASSERT_NEXT(a_div_entry, i_clk, i_rst_n,
        (r_state == S_CALC) && !(i_status.frame_done && i_status.use_div),
        r_state == S_EMIT)

endmodule

>>> src/skin_pixel_centroid.sv
// ----------------------------------------------------------------------------
// Skin pixel centroid
// Classifies RGB pixels as skin and reports a per-frame centroid.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the input channel (i_in_valid/o_in_ready)
// and one result item per pixel leaves on the output channel
// (o_out_valid/i_out_ready). Row and column are counted internally from the
// frame size registers, which the user must write through
// i_cfg_we/i_cfg_index/i_cfg_data while the block is idle; the block itself
// does not enforce this. An ordinary pixel is accepted, then classified and
// accumulated, then loaded into the output register. The last pixel of a
// frame with enough skin pixels also passes through the column and row
// quotients, which share one restoring divider producing one quotient bit
// per cycle over 37 bits each. The block accepts no new pixel until the
// previous one is in the output register, as the controller sequences each
// pixel around the single classification stage. Reset restores the default
// configuration and clears the position counters and sums. When the
// receiver stalls, the finished result holds in the output register; the
// next pixel is still accepted and processed, and then waits until the
// output register is free.
// ----------------------------------------------------------------------------
module skin_pixel_centroid (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [spc_pkg::IDX_BITS-1:0]    i_cfg_index,
    input  logic [spc_pkg::CFG_BITS-1:0]    i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [spc_pkg::PIX_BITS-1:0]    i_red,
    input  logic [spc_pkg::PIX_BITS-1:0]    i_green,
    input  logic [spc_pkg::PIX_BITS-1:0]    i_blue,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_skin_flag,
    output logic                            o_frame_done,
    output logic [spc_pkg::CENTER_BITS-1:0] o_center_x,
    output logic [spc_pkg::CENTER_BITS-1:0] o_center_y,
    output logic [spc_pkg::CNT_BITS-1:0]    o_skin_count
);
    import spc_pkg::*;

    t_spc_cmd    cmd;
    t_spc_status status;

    // Sequencer.
    spc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Classifier, accumulators and divider.
    spc_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_skin_flag  (o_skin_flag),
        .o_frame_done (o_frame_done),
        .o_center_x   (o_center_x),
        .o_center_y   (o_center_y),
        .o_skin_count (o_skin_count)
    );

endmodule
